// ----- sv/iem_pkg.sv -----
// Shared types, register indexes and selector codes of the interval edit remapper.
package iem_pkg;

    localparam int POS_BITS_DEFAULT = 32;
    localparam int COORD_W          = 32;
    localparam int SUM_W            = COORD_W + 1;
    localparam int EXT_W            = COORD_W + 3;
    localparam int CFG_INDEX_W      = 3;

    localparam logic [1:0] KIND_REMOVAL   = 2'd0;
    localparam logic [1:0] KIND_INSERTION = 2'd1;

    localparam logic [1:0] STRAT_RESIZE   = 2'd0;
    localparam logic [1:0] STRAT_REMOVE   = 2'd1;
    localparam logic [1:0] STRAT_SEPARATE = 2'd3;

    localparam logic [1:0] DEST_KEPT    = 2'd0;
    localparam logic [1:0] DEST_DELETED = 2'd1;
    localparam logic [1:0] DEST_SPLIT   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_EDIT_KIND  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STRATEGY   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EDIT_START = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OLD_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NEW_LENGTH = 3'd4;

    // Start selectors.
    localparam logic [2:0] SS_REGION   = 3'd0;
    localparam logic [2:0] SS_EDIT     = 3'd1;
    localparam logic [2:0] SS_NEW_END  = 3'd2;
    localparam logic [2:0] SS_LESS_OLD = 3'd3;
    localparam logic [2:0] SS_PLUS_NEW = 3'd4;
    localparam logic [2:0] SS_PLUS_OFF = 3'd5;

    // Length selectors.
    localparam logic [2:0] SL_REGION   = 3'd0;
    localparam logic [2:0] SL_ZERO     = 3'd1;
    localparam logic [2:0] SL_LESS_OLD = 3'd2;
    localparam logic [2:0] SL_HEAD     = 3'd3;
    localparam logic [2:0] SL_TAIL     = 3'd4;
    localparam logic [2:0] SL_PLUS_NEW = 3'd5;
    localparam logic [2:0] SL_PLUS_OFF = 3'd6;

    // Handling of a result whose length comes out as zero.
    localparam logic [1:0] ZM_NONE    = 2'd0;
    localparam logic [1:0] ZM_DELETE  = 2'd1;
    localparam logic [1:0] ZM_RESTORE = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] region_start;
        logic [COORD_W-1:0] region_length;
    } region_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_start;
        logic [COORD_W-1:0] out_length;
        logic [1:0]         destination;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0]              edit_kind;
        logic [1:0]              strategy;
        logic [COORD_W-1:0]      edit_start;
        logic [COORD_W-1:0]      old_length;
        logic [COORD_W-1:0]      new_length;
        logic [SUM_W-1:0]        edit_end;
        logic [SUM_W-1:0]        new_end;
        logic signed [SUM_W-1:0] offset;
    } cfg_t;

    typedef struct packed {
        region_t          region;
        logic [SUM_W-1:0] end_pos;
        logic [2:0]       sel_start;
        logic [2:0]       sel_len;
        logic [1:0]       dest;
        logic [1:0]       zero_mode;
        logic             split;
        logic [1:0]       dest2;
    } decode_t;

    typedef struct packed {
        logic signed [EXT_W-1:0] start;
        logic signed [EXT_W-1:0] length;
        region_t                 orig;
        logic [1:0]              dest;
        logic [1:0]              zero_mode;
        logic                    split;
        logic [SUM_W-1:0]        start2;
        logic [SUM_W-1:0]        length2;
        logic [1:0]              dest2;
    } calc_t;

    function automatic logic signed [EXT_W-1:0] widen(input logic [SUM_W-1:0] v);
        return $signed({{(EXT_W - SUM_W){1'b0}}, v});
    endfunction

endpackage

// ----- sv/interval_edit_remapper.sv -----
// Top level of the interval edit remapper: configuration, decode, arithmetic and output stages.
//
// Channel   Ports                          Transfer
// config    cfg_we, cfg_index, cfg_data    write at each clock edge with cfg_we high
// region    start, busy, region            transaction at a clock edge with start high, busy low
// result    result_strobe, result          one transaction per cycle with result_strobe high
//
// A region can be accepted in every cycle in which busy is low. Its first result is driven
// through the capture, decode, arithmetic and output registers.
// A region cut in two by a split insertion gives two results in consecutive cycles; busy
// is high for the cycle of the first one, and the whole pipeline holds at the edge ending it.
// Reset clears the edit registers to zero and empties the pipeline.
// Results cannot be held off by the receiver.
module interval_edit_remapper #(
    parameter int POS_BITS = iem_pkg::POS_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [iem_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [iem_pkg::COORD_W-1:0]         cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  iem_pkg::region_t                    region,
    output logic                                result_strobe,
    output iem_pkg::result_t                    result
);

    iem_pkg::cfg_t    cfg;
    iem_pkg::decode_t decode;
    iem_pkg::calc_t   calc;
    logic             accept;
    logic             advance;
    logic             decode_valid;
    logic             calc_valid;

    assign accept  = start && !busy;
    assign advance = !busy;

    iem_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iem_classify u_classify (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .accept  (accept),
        .region  (region),
        .cfg     (cfg),
        .valid   (decode_valid),
        .decode  (decode)
    );

    iem_compute u_compute (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .valid_in (decode_valid),
        .decode   (decode),
        .cfg      (cfg),
        .valid    (calc_valid),
        .calc     (calc)
    );

    iem_output #(
        .POS_BITS (POS_BITS)
    ) u_output (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid         (calc_valid),
        .calc          (calc),
        .busy          (busy),
        .result_strobe (result_strobe),
        .result        (result)
    );

`ifndef SYNTHESIS
    // The cycle after a split first part always carries the closing second part.
    a_split_second: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> result_strobe && result.last_of_run)
        else $error("second part of a split did not follow");

    a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("pipeline held for more than one cycle");

    a_first_part: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last_of_run |-> busy)
        else $error("first part of a split without a held pipeline");

    a_dest_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> result.destination == iem_pkg::DEST_KEPT
                       || result.destination == iem_pkg::DEST_DELETED
                       || result.destination == iem_pkg::DEST_SPLIT)
        else $error("result destination out of range");
`endif

endmodule

// ----- sv/iem_cfg.sv -----
// Edit configuration registers and the sums derived from them.
module iem_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [iem_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [iem_pkg::COORD_W-1:0]         cfg_data,
    output iem_pkg::cfg_t                       cfg
);

    logic [1:0]                       edit_kind_reg, edit_kind_next;
    logic [1:0]                       strategy_reg, strategy_next;
    logic [iem_pkg::COORD_W-1:0]      edit_start_reg, edit_start_next;
    logic [iem_pkg::COORD_W-1:0]      old_length_reg, old_length_next;
    logic [iem_pkg::COORD_W-1:0]      new_length_reg, new_length_next;
    logic [iem_pkg::SUM_W-1:0]        edit_end_reg, edit_end_next;
    logic [iem_pkg::SUM_W-1:0]        new_end_reg, new_end_next;
    logic signed [iem_pkg::SUM_W-1:0] offset_reg, offset_next;

    always_comb
    begin
        edit_kind_next  = edit_kind_reg;
        strategy_next   = strategy_reg;
        edit_start_next = edit_start_reg;
        old_length_next = old_length_reg;
        new_length_next = new_length_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                iem_pkg::REG_EDIT_KIND:  edit_kind_next  = cfg_data[1:0];
                iem_pkg::REG_STRATEGY:   strategy_next   = cfg_data[1:0];
                iem_pkg::REG_EDIT_START: edit_start_next = cfg_data;
                iem_pkg::REG_OLD_LENGTH: old_length_next = cfg_data;
                iem_pkg::REG_NEW_LENGTH: new_length_next = cfg_data;
                default: ;
            endcase
        end
    end

    // The derived sums are registered from the edit registers, so they follow them in the next cycle.
    assign edit_end_next = {1'b0, edit_start_reg} + {1'b0, old_length_reg};
    assign new_end_next  = {1'b0, edit_start_reg} + {1'b0, new_length_reg};
    assign offset_next   = $signed({1'b0, new_length_reg}) - $signed({1'b0, old_length_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edit_kind_reg  <= '0;
            strategy_reg   <= '0;
            edit_start_reg <= '0;
            old_length_reg <= '0;
            new_length_reg <= '0;
            edit_end_reg   <= '0;
            new_end_reg    <= '0;
            offset_reg     <= '0;
        end
        else
        begin
            edit_kind_reg  <= edit_kind_next;
            strategy_reg   <= strategy_next;
            edit_start_reg <= edit_start_next;
            old_length_reg <= old_length_next;
            new_length_reg <= new_length_next;
            edit_end_reg   <= edit_end_next;
            new_end_reg    <= new_end_next;
            offset_reg     <= offset_next;
        end
    end

    assign cfg.edit_kind  = edit_kind_reg;
    assign cfg.strategy   = strategy_reg;
    assign cfg.edit_start = edit_start_reg;
    assign cfg.old_length = old_length_reg;
    assign cfg.new_length = new_length_reg;
    assign cfg.edit_end   = edit_end_reg;
    assign cfg.new_end    = new_end_reg;
    assign cfg.offset     = offset_reg;

endmodule

// ----- sv/iem_classify.sv -----
// Capture stage and decode stage: compares each region against the edit and picks the formulae.
module iem_classify (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                accept,
    input  iem_pkg::region_t    region,
    input  iem_pkg::cfg_t       cfg,
    output logic                valid,
    output iem_pkg::decode_t    decode
);

    logic                         s1_valid_reg;
    iem_pkg::region_t             s1_region_reg;
    logic [iem_pkg::SUM_W-1:0]    s1_end_reg, s1_end_next;
    logic                         s2_valid_reg;
    iem_pkg::decode_t             s2_decode_reg, s2_decode_next;

    logic [iem_pkg::COORD_W-1:0]  s_pos;
    logic [iem_pkg::SUM_W-1:0]    s_wide;
    logic [iem_pkg::SUM_W-1:0]    es_wide;
    logic s_lt_es, s_le_es, end_le_es, e_le_end, end_le_e, s_ge_e, s_lt_ne, end_le_ne;
    logic off_zero, off_pos, hit, holds_a, holds_b;

    assign s1_end_next = {1'b0, region.region_start} + {1'b0, region.region_length};

    assign s_pos   = s1_region_reg.region_start;
    assign s_wide  = {1'b0, s_pos};
    assign es_wide = {1'b0, cfg.edit_start};

    assign s_lt_es   = s_pos < cfg.edit_start;
    assign s_le_es   = s_pos <= cfg.edit_start;
    assign end_le_es = s1_end_reg <= es_wide;
    assign e_le_end  = cfg.edit_end <= s1_end_reg;
    assign end_le_e  = s1_end_reg <= cfg.edit_end;
    assign s_ge_e    = s_wide >= cfg.edit_end;
    assign s_lt_ne   = s_wide < cfg.new_end;
    assign end_le_ne = s1_end_reg <= cfg.new_end;
    assign off_zero  = cfg.offset == '0;
    assign off_pos   = !cfg.offset[iem_pkg::SUM_W-1] && !off_zero;

    // The region meets the edited stretch, or it contains the edit, or the edit contains it.
    assign hit     = s_lt_es ? !end_le_es : !s_ge_e;
    assign holds_a = s_le_es && e_le_end;
    assign holds_b = !s_lt_es && end_le_e;

    always_comb
    begin
        s2_decode_next           = '0;
        s2_decode_next.region    = s1_region_reg;
        s2_decode_next.end_pos   = s1_end_reg;
        s2_decode_next.sel_start = iem_pkg::SS_REGION;
        s2_decode_next.sel_len   = iem_pkg::SL_REGION;
        s2_decode_next.dest      = iem_pkg::DEST_KEPT;
        s2_decode_next.zero_mode = iem_pkg::ZM_NONE;
        s2_decode_next.split     = 1'b0;
        s2_decode_next.dest2     = iem_pkg::DEST_KEPT;
        case (cfg.edit_kind)
            iem_pkg::KIND_REMOVAL:
            begin
                s2_decode_next.zero_mode = iem_pkg::ZM_RESTORE;
                if (cfg.strategy == iem_pkg::STRAT_REMOVE)
                begin
                    if (hit || holds_b)
                        s2_decode_next.sel_len = iem_pkg::SL_ZERO;
                    else if (s_ge_e)
                        s2_decode_next.sel_start = iem_pkg::SS_LESS_OLD;
                end
                else if (holds_a)
                    s2_decode_next.sel_len = iem_pkg::SL_LESS_OLD;
                else if (holds_b)
                    s2_decode_next.sel_len = iem_pkg::SL_ZERO;
                else if (hit)
                begin
                    if (s_le_es)
                        s2_decode_next.sel_len = iem_pkg::SL_HEAD;
                    else
                    begin
                        s2_decode_next.sel_start = iem_pkg::SS_EDIT;
                        s2_decode_next.sel_len   = iem_pkg::SL_TAIL;
                    end
                end
                else if (s_ge_e)
                    s2_decode_next.sel_start = iem_pkg::SS_LESS_OLD;
            end
            iem_pkg::KIND_INSERTION:
            begin
                if (end_le_es)
                    s2_decode_next.dest = iem_pkg::DEST_KEPT;
                else if (!s_lt_es)
                begin
                    s2_decode_next.sel_start = iem_pkg::SS_PLUS_NEW;
                    if (cfg.strategy == iem_pkg::STRAT_SEPARATE)
                        s2_decode_next.dest = iem_pkg::DEST_SPLIT;
                end
                else
                begin
                    case (cfg.strategy)
                        iem_pkg::STRAT_RESIZE: s2_decode_next.sel_len = iem_pkg::SL_PLUS_NEW;
                        iem_pkg::STRAT_REMOVE: s2_decode_next.dest = iem_pkg::DEST_DELETED;
                        default:
                        begin
                            s2_decode_next.sel_len = iem_pkg::SL_HEAD;
                            s2_decode_next.split   = 1'b1;
                            if (cfg.strategy == iem_pkg::STRAT_SEPARATE)
                                s2_decode_next.dest2 = iem_pkg::DEST_SPLIT;
                        end
                    endcase
                end
            end
            default:
            begin
                if (cfg.strategy == iem_pkg::STRAT_REMOVE)
                begin
                    // A removal followed by an insertion, both under the remove strategy.
                    s2_decode_next.zero_mode = iem_pkg::ZM_RESTORE;
                    if (hit || holds_b)
                        s2_decode_next.sel_len = iem_pkg::SL_ZERO;
                    else if (s_ge_e)
                        s2_decode_next.sel_start = iem_pkg::SS_PLUS_OFF;
                    else if (end_le_es)
                        s2_decode_next.dest = iem_pkg::DEST_KEPT;
                    else if (s_lt_es)
                        s2_decode_next.dest = iem_pkg::DEST_DELETED;
                    else
                        s2_decode_next.sel_start = iem_pkg::SS_PLUS_NEW;
                end
                else
                begin
                    s2_decode_next.zero_mode = iem_pkg::ZM_DELETE;
                    if (off_zero || end_le_es)
                    begin
                        // Untouched regions stay kept even when their length is zero.
                        s2_decode_next.dest      = iem_pkg::DEST_KEPT;
                        s2_decode_next.zero_mode = iem_pkg::ZM_NONE;
                    end
                    else if (holds_a)
                        s2_decode_next.sel_len = iem_pkg::SL_PLUS_OFF;
                    else if (s_ge_e)
                        s2_decode_next.sel_start = iem_pkg::SS_PLUS_OFF;
                    else if (off_pos)
                    begin
                        if (!end_le_e)
                            s2_decode_next.sel_len = iem_pkg::SL_PLUS_OFF;
                    end
                    else if (end_le_ne)
                        s2_decode_next.dest = iem_pkg::DEST_KEPT;
                    else if (s_lt_ne && e_le_end)
                        s2_decode_next.sel_len = iem_pkg::SL_PLUS_OFF;
                    else if (!s_lt_ne && end_le_e)
                        s2_decode_next.sel_len = iem_pkg::SL_ZERO;
                    else if (s_lt_ne)
                        s2_decode_next.sel_len = iem_pkg::SL_HEAD;
                    else
                    begin
                        s2_decode_next.sel_start = iem_pkg::SS_NEW_END;
                        s2_decode_next.sel_len   = iem_pkg::SL_TAIL;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_region_reg <= region;
            s1_end_reg    <= s1_end_next;
            s2_decode_reg <= s2_decode_next;
        end
    end

    assign valid  = s2_valid_reg;
    assign decode = s2_decode_reg;

endmodule

// ----- sv/iem_compute.sv -----
// Arithmetic stage: forms the exact start and length of each result from the decoded selection.
module iem_compute (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                valid_in,
    input  iem_pkg::decode_t    decode,
    input  iem_pkg::cfg_t       cfg,
    output logic                valid,
    output iem_pkg::calc_t      calc
);

    logic                             s3_valid_reg;
    iem_pkg::calc_t                   s3_calc_reg, s3_calc_next;
    logic signed [iem_pkg::EXT_W-1:0] s_x, l_x, es_x, ol_x, nl_x, end_x, e_x, ne_x, off_x;

    assign s_x   = iem_pkg::widen({1'b0, decode.region.region_start});
    assign l_x   = iem_pkg::widen({1'b0, decode.region.region_length});
    assign es_x  = iem_pkg::widen({1'b0, cfg.edit_start});
    assign ol_x  = iem_pkg::widen({1'b0, cfg.old_length});
    assign nl_x  = iem_pkg::widen({1'b0, cfg.new_length});
    assign end_x = iem_pkg::widen(decode.end_pos);
    assign e_x   = iem_pkg::widen(cfg.edit_end);
    assign ne_x  = iem_pkg::widen(cfg.new_end);
    assign off_x = {{(iem_pkg::EXT_W - iem_pkg::SUM_W){cfg.offset[iem_pkg::SUM_W-1]}},
                    cfg.offset};

    always_comb
    begin
        s3_calc_next           = '0;
        s3_calc_next.orig      = decode.region;
        s3_calc_next.dest      = decode.dest;
        s3_calc_next.zero_mode = decode.zero_mode;
        s3_calc_next.split     = decode.split;
        s3_calc_next.dest2     = decode.dest2;
        s3_calc_next.start2    = cfg.new_end;
        s3_calc_next.length2   = decode.end_pos - {1'b0, cfg.edit_start};
        case (decode.sel_start)
            iem_pkg::SS_REGION:   s3_calc_next.start = s_x;
            iem_pkg::SS_EDIT:     s3_calc_next.start = es_x;
            iem_pkg::SS_NEW_END:  s3_calc_next.start = ne_x;
            iem_pkg::SS_LESS_OLD: s3_calc_next.start = s_x - ol_x;
            iem_pkg::SS_PLUS_NEW: s3_calc_next.start = s_x + nl_x;
            iem_pkg::SS_PLUS_OFF: s3_calc_next.start = s_x + off_x;
            default:              s3_calc_next.start = s_x;
        endcase
        case (decode.sel_len)
            iem_pkg::SL_REGION:   s3_calc_next.length = l_x;
            iem_pkg::SL_ZERO:     s3_calc_next.length = '0;
            iem_pkg::SL_LESS_OLD: s3_calc_next.length = l_x - ol_x;
            iem_pkg::SL_HEAD:     s3_calc_next.length = es_x - s_x;
            iem_pkg::SL_TAIL:     s3_calc_next.length = end_x - e_x;
            iem_pkg::SL_PLUS_NEW: s3_calc_next.length = l_x + nl_x;
            iem_pkg::SL_PLUS_OFF: s3_calc_next.length = l_x + off_x;
            default:              s3_calc_next.length = l_x;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (advance)
            s3_valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            s3_calc_reg <= s3_calc_next;
    end

    assign valid = s3_valid_reg;
    assign calc  = s3_calc_reg;

endmodule

// ----- sv/iem_output.sv -----
// Output stage: saturation, deletion rules and sequencing of the second result of a split.
module iem_output #(
    parameter int POS_BITS = iem_pkg::POS_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    input  iem_pkg::calc_t      calc,
    output logic                busy,
    output logic                result_strobe,
    output iem_pkg::result_t    result
);

    localparam int CW = iem_pkg::COORD_W;
    localparam logic [CW-1:0] SAT_LIMIT =
        (POS_BITS >= CW) ? {CW{1'b1}} : CW'((64'd1 << POS_BITS) - 64'd1);
    localparam logic signed [iem_pkg::EXT_W-1:0] LIMIT_X = iem_pkg::widen({1'b0, SAT_LIMIT});

    iem_pkg::result_t result_reg, result_next;
    iem_pkg::result_t spare_reg, spare_next;
    logic             strobe_reg, strobe_next;
    logic             pend_reg, pend_next;
    iem_pkg::result_t beat0, beat1;
    logic             zero_len;

    function automatic logic [CW-1:0] clip(input logic signed [iem_pkg::EXT_W-1:0] v);
        logic [CW-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > LIMIT_X)
            r = SAT_LIMIT;
        else
            r = v[CW-1:0];
        return r;
    endfunction

    assign zero_len = calc.length[iem_pkg::EXT_W-1] || (calc.length == '0);

    always_comb
    begin
        beat0.out_start   = clip(calc.start);
        beat0.out_length  = clip(calc.length);
        beat0.destination = calc.dest;
        beat0.last_of_run = !calc.split;
        case (calc.zero_mode)
            iem_pkg::ZM_DELETE:
            begin
                if (zero_len)
                    beat0.destination = iem_pkg::DEST_DELETED;
            end
            iem_pkg::ZM_RESTORE:
            begin
                // A removed region is reported as it was before the edit.
                if (zero_len)
                begin
                    beat0.out_start   = clip(iem_pkg::widen({1'b0, calc.orig.region_start}));
                    beat0.out_length  = clip(iem_pkg::widen({1'b0, calc.orig.region_length}));
                    beat0.destination = iem_pkg::DEST_DELETED;
                end
            end
            default: ;
        endcase
        beat1.out_start   = clip(iem_pkg::widen(calc.start2));
        beat1.out_length  = clip(iem_pkg::widen(calc.length2));
        beat1.destination = calc.dest2;
        beat1.last_of_run = 1'b1;
    end

    always_comb
    begin
        result_next = result_reg;
        spare_next  = spare_reg;
        strobe_next = 1'b0;
        pend_next   = 1'b0;
        if (pend_reg)
        begin
            result_next = spare_reg;
            strobe_next = 1'b1;
        end
        else
        begin
            spare_next = beat1;
            if (valid)
            begin
                result_next = beat0;
                strobe_next = 1'b1;
                pend_next   = calc.split;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        spare_reg  <= spare_next;
    end

    assign busy          = pend_reg;
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule
